>>> hw/rtl/channel_link_pulse_classifier_core_macros.svh
// Assertion macros shared by the channel link pulse classifier RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef CHANNEL_LINK_PULSE_CLASSIFIER_CORE_MACROS_SVH
`define CHANNEL_LINK_PULSE_CLASSIFIER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define CLPC_ASSERT_COMB(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clpc check failed");
// Next-cycle implication, disabled while reset is asserted.
`define CLPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clpc check failed");
`else
`define CLPC_ASSERT_COMB(label, clk, rst_n, ante, cons)
`define CLPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/clpc_pkg.sv
// Shared types and constants for the channel link pulse classifier.
// No dependencies.
package clpc_pkg;

    localparam int CFG_DATA_BITS  = 8;
    localparam int CFG_INDEX_BITS = 2;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SHORT_LOW_ABOVE = 2'd0,
        REG_SHORT_LOW_BELOW = 2'd1,
        REG_LONG_LOW_ABOVE  = 2'd2
    } clpc_reg_index_t;

    // Reset values of the width thresholds
    localparam logic [CFG_DATA_BITS-1:0] SHORT_LOW_ABOVE_RST = 8'd2;
    localparam logic [CFG_DATA_BITS-1:0] SHORT_LOW_BELOW_RST = 8'd20;
    localparam logic [CFG_DATA_BITS-1:0] LONG_LOW_ABOVE_RST  = 8'd30;

    // Item operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Width thresholds as seen by each channel
    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] short_low_above;
        logic [CFG_DATA_BITS-1:0] short_low_below;
        logic [CFG_DATA_BITS-1:0] long_low_above;
    } clpc_thresh_t;

endpackage

>>> hw/rtl/clpc_cfg.sv
// Threshold register file written through the plain configuration port.
// Depends on clpc_pkg.
module clpc_cfg
    import clpc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output clpc_thresh_t              thresh
);

    clpc_thresh_t thresh_reg;
    clpc_thresh_t thresh_next;

    // Index decode; an index beyond the list is dropped
    always_comb
    begin
        thresh_next = thresh_reg;
        if (cfg_we)
        begin
            unique case (clpc_reg_index_t'(cfg_index))
                REG_SHORT_LOW_ABOVE: thresh_next.short_low_above = cfg_data;
                REG_SHORT_LOW_BELOW: thresh_next.short_low_below = cfg_data;
                REG_LONG_LOW_ABOVE:  thresh_next.long_low_above  = cfg_data;
                default:             thresh_next = thresh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.short_low_above <= SHORT_LOW_ABOVE_RST;
            thresh_reg.short_low_below <= SHORT_LOW_BELOW_RST;
            thresh_reg.long_low_above  <= LONG_LOW_ABOVE_RST;
        end
        else
        begin
            thresh_reg <= thresh_next;
        end
    end

    assign thresh = thresh_reg;

endmodule

>>> hw/rtl/clpc_chan.sv
// One monitor channel: low pulse start capture, width measure and classification.
// Depends on clpc_pkg.
module clpc_chan
    import clpc_pkg::*;
#(
    parameter int TICK_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 line_high,
    input  logic [TICK_BITS-1:0] tick_count,
    input  clpc_thresh_t         thresh,
    output logic                 lost,
    output logic                 rejoined
);

    logic                 low_active_reg;
    logic                 low_active_next;
    logic [TICK_BITS-1:0] low_start_reg;
    logic [TICK_BITS-1:0] width;
    logic                 in_short;
    logic                 pulse_end;

    // Wrapping low width and window tests
    assign width     = tick_count - low_start_reg;
    assign pulse_end = line_high && low_active_reg;
    assign in_short  = (width > TICK_BITS'(thresh.short_low_above))
                    && (width < TICK_BITS'(thresh.short_low_below));
    assign lost      = pulse_end && in_short;
    assign rejoined  = pulse_end && !in_short
                    && (width > TICK_BITS'(thresh.long_low_above));

    // Low pulse tracking
    always_comb
    begin
        low_active_next = low_active_reg;
        if (step)
        begin
            low_active_next = !line_high;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_active_reg <= 1'b0;
        end
        else
        begin
            low_active_reg <= low_active_next;
        end
    end

    // Start tick of the current low pulse, captured on the falling sample
    always_ff @(posedge clk)
    begin
        if (step && !line_high && !low_active_reg)
        begin
            low_start_reg <= tick_count;
        end
    end

endmodule

>>> hw/rtl/channel_link_pulse_classifier_core.sv
// Top level of the channel link pulse classifier: input stage, channel cells,
// result register. Depends on clpc_pkg, clpc_cfg, clpc_chan and the macro header.
`include "channel_link_pulse_classifier_core_macros.svh"

// Takes one item per clock cycle while out_ready holds; the input register hands each
// item to the result register once that register is free or being read, and the
// result can then transfer out. The rate is set by the channel update, a TICK_BITS-wide
// subtract and three compares per channel between the input register and the result
// register. While a finished result waits, one more item can enter the input register.
// Thresholds are to be written only while idle; the user is bound, the block itself
// does not enforce it.
module channel_link_pulse_classifier_core
    import clpc_pkg::*;
#(
    parameter int CHANNELS  = 6,
    parameter int TICK_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      operation,
    input  logic [CHANNELS-1:0]       line_levels,
    input  logic [CHANNELS-1:0]       mask_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [CHANNELS-1:0]       pair_mask,
    output logic [CHANNELS-1:0]       lost_channels,
    output logic [CHANNELS-1:0]       rejoined_channels,
    output logic                      mask_changed
);

    clpc_thresh_t thresh;

    logic                 stage_valid_reg;
    logic                 stage_op_reg;
    logic [CHANNELS-1:0]  stage_lines_reg;
    logic [CHANNELS-1:0]  stage_mask_reg;
    logic                 stage_adv;
    logic                 tick_step;

    logic [TICK_BITS-1:0] tick_count_reg;
    logic [CHANNELS-1:0]  pair_bits_reg;
    logic [CHANNELS-1:0]  pair_bits_next;
    logic [CHANNELS-1:0]  lost_vec;
    logic [CHANNELS-1:0]  rejoin_vec;

    logic                 out_valid_reg;
    logic [CHANNELS-1:0]  out_pair_reg;
    logic [CHANNELS-1:0]  out_lost_reg;
    logic [CHANNELS-1:0]  out_rejoin_reg;
    logic                 out_changed_reg;

    clpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thresh    (thresh)
    );

    // Handshake: the stage moves on when the result register is free
    assign stage_adv = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || stage_adv;
    assign tick_step = stage_adv && (stage_op_reg == OP_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_op_reg    <= operation;
            stage_lines_reg <= line_levels;
            stage_mask_reg  <= mask_value;
        end
    end

    // Channel cells
    for (genvar b = 0; b < CHANNELS; b++)
    begin : g_chan
        clpc_chan #(
            .TICK_BITS (TICK_BITS)
        ) u_chan (
            .clk        (clk),
            .rst_n      (rst_n),
            .step       (tick_step),
            .line_high  (stage_lines_reg[b]),
            .tick_count (tick_count_reg),
            .thresh     (thresh),
            .lost       (lost_vec[b]),
            .rejoined   (rejoin_vec[b])
        );
    end

    // Pair mask update: a load takes the mask value; else lost clears, rejoined sets (never both)
    always_comb
    begin
        if (stage_op_reg == OP_LOAD)
        begin
            pair_bits_next = stage_mask_reg;
        end
        else
        begin
            pair_bits_next = (pair_bits_reg & ~lost_vec) | rejoin_vec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            pair_bits_reg  <= '0;
        end
        else
        begin
            if (tick_step)
            begin
                tick_count_reg <= tick_count_reg + TICK_BITS'(1);
            end
            if (stage_adv)
            begin
                pair_bits_reg <= pair_bits_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv)
        begin
            out_pair_reg <= pair_bits_next;
            if (stage_op_reg == OP_LOAD)
            begin
                out_lost_reg    <= '0;
                out_rejoin_reg  <= '0;
                out_changed_reg <= 1'b0;
            end
            else
            begin
                out_lost_reg    <= lost_vec;
                out_rejoin_reg  <= rejoin_vec;
                out_changed_reg <= (pair_bits_next != pair_bits_reg);
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign pair_mask         = out_pair_reg;
    assign lost_channels     = out_lost_reg;
    assign rejoined_channels = out_rejoin_reg;
    assign mask_changed      = out_changed_reg;

    // Checks
    `CLPC_ASSERT_COMB(a_lost_rejoin_disjoint, clk, rst_n, out_valid_reg, (out_lost_reg & out_rejoin_reg) == '0)
    `CLPC_ASSERT_COMB(a_change_has_cause, clk, rst_n, out_valid_reg && out_changed_reg, (out_lost_reg | out_rejoin_reg) != '0)
    `CLPC_ASSERT_NEXT(a_tick_advance, clk, rst_n, tick_step, tick_count_reg == TICK_BITS'($past(tick_count_reg) + TICK_BITS'(1)))
    `CLPC_ASSERT_NEXT(a_stage_holds, clk, rst_n, stage_valid_reg && !stage_adv, stage_valid_reg)
    `CLPC_ASSERT_NEXT(a_pair_stable, clk, rst_n, !stage_adv, $stable(pair_bits_reg))

endmodule
